// ===== sv/pressure_command_line_parser_core_macros.svh =====
// Assertion macros shared by the parser modules.
`ifndef PRESSURE_COMMAND_LINE_PARSER_CORE_MACROS_SVH
`define PRESSURE_COMMAND_LINE_PARSER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PCLP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define PCLP_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define PCLP_ASSERT(label, clk, rst_n, prop)
`define PCLP_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ===== sv/pclp_pkg.sv =====
package pclp_pkg;

  localparam int unsigned Channels = 7;
  localparam int unsigned LenSensor = 16;
  localparam int unsigned LenClear = 9;
  localparam int unsigned LenCell = 30;
  localparam logic [16:0] MagCap = 17'd32768;
  localparam logic [16:0] RowCap = 17'd65536;

  typedef enum logic [2:0] {
    KIND_INVALID  = 3'd0,
    KIND_SENSOR   = 3'd1,
    KIND_CLEAR    = 3'd2,
    KIND_TIME     = 3'd3,
    KIND_PRESSURE = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SIGN   = 3'd1,
    PH_INT    = 3'd2,
    PH_POINT  = 3'd3,
    PH_TENTH  = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0] character;
    logic       line_end;
  } item_t;

  typedef struct packed {
    logic                  commit_sensor;
    logic                  commit_time;
    logic                  commit_pres;
    logic                  write_pending;
    logic [2:0]            pend_index;
    logic [15:0]           value;
    logic [15:0]           row;
    kind_e                 kind;
    logic                  emit;
  } ctrl_t;

  function automatic logic [7:0] sensor_char(input logic [5:0] p);
    case (p)
      6'd0: sensor_char = "L";  6'd1: sensor_char = "A";  6'd2: sensor_char = "B";
      6'd3: sensor_char = "E";  6'd4: sensor_char = "L";  6'd5: sensor_char = ",";
      6'd6: sensor_char = "D";  6'd7: sensor_char = "a";  6'd8: sensor_char = "t";
      6'd9: sensor_char = "e";  6'd10: sensor_char = ","; 6'd11: sensor_char = "T";
      6'd12: sensor_char = "i"; 6'd13: sensor_char = "m"; 6'd14: sensor_char = "e";
      6'd15: sensor_char = ",";
      default: sensor_char = 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] clear_char(input logic [5:0] p);
    case (p)
      6'd0: clear_char = "C"; 6'd1: clear_char = "L"; 6'd2: clear_char = "E";
      6'd3: clear_char = "A"; 6'd4: clear_char = "R"; 6'd5: clear_char = "D";
      6'd6: clear_char = "A"; 6'd7: clear_char = "T"; 6'd8: clear_char = "A";
      default: clear_char = 8'd0;
    endcase
  endfunction

  // Row request prefix; the 29th character selects time (A) or pressure (B).
  function automatic logic [7:0] cell_char(input logic [5:0] p, input logic pres);
    case (p)
      6'd0: cell_char = "C";  6'd1: cell_char = "E";  6'd2: cell_char = "L";
      6'd3: cell_char = "L";  6'd4: cell_char = ",";  6'd5: cell_char = "G";
      6'd6: cell_char = "E";  6'd7: cell_char = "T";  6'd8: cell_char = ",";
      6'd9: cell_char = "F";  6'd10: cell_char = "R"; 6'd11: cell_char = "O";
      6'd12: cell_char = "M"; 6'd13: cell_char = "S"; 6'd14: cell_char = "H";
      6'd15: cell_char = "E"; 6'd16: cell_char = "E"; 6'd17: cell_char = "T";
      6'd18: cell_char = ","; 6'd19: cell_char = "S"; 6'd20: cell_char = "e";
      6'd21: cell_char = "t"; 6'd22: cell_char = "t"; 6'd23: cell_char = "i";
      6'd24: cell_char = "n"; 6'd25: cell_char = "g"; 6'd26: cell_char = "s";
      6'd27: cell_char = ",";
      6'd28: cell_char = pres ? "B" : "A";
      6'd29: cell_char = ",";
      default: cell_char = 8'd0;
    endcase
  endfunction

endpackage

// ===== sv/pclp_scan.sv =====
module pclp_scan (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  pclp_pkg::item_t item_i,
  output pclp_pkg::ctrl_t ctrl_o
);
  import pclp_pkg::*;
  `include "pressure_command_line_parser_core_macros.svh"

  logic [3:0]  alive_q, alive_d;
  logic [5:0]  pos_q, pos_d;
  logic [2:0]  fidx_q, fidx_d;
  phase_e      phase_q, phase_d;
  logic        neg_q, neg_d;
  logic [16:0] acc_q, acc_d;
  logic        row_seen_q, row_seen_d;

  logic [7:0]  c;
  logic        dig;
  logic [3:0]  d;
  logic [20:0] mac;
  logic [16:0] mag_sat, row_sat;
  logic [16:0] m;
  logic [15:0] tenths;
  logic [3:0]  al;
  logic        last_ok;

  assign c = item_i.character;
  assign dig = (c >= "0") && (c <= "9");
  assign d = c[3:0];
  assign mac = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + {17'd0, d};
  assign mag_sat = (mac > {4'd0, MagCap}) ? MagCap : mac[16:0];
  assign row_sat = (mac > {4'd0, RowCap}) ? RowCap : mac[16:0];

  always_comb begin
    al = alive_q;
    fidx_d = fidx_q;
    phase_d = phase_q;
    neg_d = neg_q;
    acc_d = acc_q;
    row_seen_d = row_seen_q;
    ctrl_o = '0;
    ctrl_o.pend_index = fidx_q;
    if (alive_q[0]) begin
      if (pos_q < 6'(LenSensor)) begin
        if (c != sensor_char(pos_q)) al[0] = 1'b0;
      end else begin
        case (phase_q)
          PH_START: begin
            if (c == "-") begin
              neg_d = 1'b1; phase_d = PH_SIGN;
            end else if (dig) begin
              acc_d = {13'd0, d}; phase_d = PH_INT;
            end else al[0] = 1'b0;
          end
          PH_SIGN: begin
            if (dig) begin
              acc_d = {13'd0, d}; phase_d = PH_INT;
            end else al[0] = 1'b0;
          end
          PH_INT: begin
            if (dig) acc_d = mag_sat;
            else if (c == ".") phase_d = PH_POINT;
            else al[0] = 1'b0;
          end
          PH_POINT: begin
            if (dig) begin
              acc_d = mag_sat; phase_d = PH_TENTH;
            end else al[0] = 1'b0;
          end
          PH_TENTH: begin
            if (c == "," && fidx_q < 3'(Channels - 1)) begin
              ctrl_o.write_pending = 1'b1;
              fidx_d = fidx_q + 3'd1;
              phase_d = PH_START;
              neg_d = 1'b0;
              acc_d = '0;
            end else al[0] = 1'b0;
          end
          default: al[0] = 1'b0;
        endcase
      end
    end
    if (alive_q[1]) begin
      if (pos_q >= 6'(LenClear) || c != clear_char(pos_q)) al[1] = 1'b0;
    end
    // Row candidates share the accumulator; at most one survives past the prefix.
    for (int k = 0; k < 2; k++) begin
      if (alive_q[2+k]) begin
        if (pos_q < 6'(LenCell)) begin
          if (c != cell_char(pos_q, k[0])) al[2+k] = 1'b0;
        end else if (dig) begin
          acc_d = row_sat; row_seen_d = 1'b1;
        end else al[2+k] = 1'b0;
      end
    end
    alive_d = al;
    pos_d = (pos_q < 6'd63) ? pos_q + 6'd1 : 6'd63;

    // A separator stores the finished value; the tenth digit completes the last one.
    begin
      m = (phase_q == PH_TENTH) ? acc_q : mag_sat;
      m = (m > MagCap) ? MagCap : m;
      if (neg_q) tenths = 16'(17'h10000 - m);
      else tenths = (m > 17'd32767) ? 16'd32767 : m[15:0];
    end
    ctrl_o.value = tenths;
    ctrl_o.row = acc_d[15:0];
    ctrl_o.kind = KIND_INVALID;
    ctrl_o.emit = item_i.line_end;
    last_ok = (acc_d < RowCap) && row_seen_d && (pos_q >= 6'(LenCell));
    if (item_i.line_end) begin
      if (al[0] && pos_q >= 6'(LenSensor) && phase_d == PH_TENTH &&
          fidx_d == 3'(Channels - 1)) begin
        ctrl_o.kind = KIND_SENSOR;
        ctrl_o.commit_sensor = 1'b1;
        ctrl_o.write_pending = 1'b1;
      end else if (al[1] && pos_d == 6'(LenClear)) begin
        ctrl_o.kind = KIND_CLEAR;
      end else if (al[2] && last_ok) begin
        ctrl_o.kind = KIND_TIME;
        ctrl_o.commit_time = 1'b1;
      end else if (al[3] && last_ok) begin
        ctrl_o.kind = KIND_PRESSURE;
        ctrl_o.commit_pres = 1'b1;
      end
      alive_d = 4'hF;
      pos_d = '0;
      fidx_d = '0;
      phase_d = PH_START;
      neg_d = 1'b0;
      acc_d = '0;
      row_seen_d = 1'b0;
    end
    if (!en_i) ctrl_o = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= 4'hF;
      pos_q <= '0;
      fidx_q <= '0;
      phase_q <= PH_START;
      neg_q <= 1'b0;
      acc_q <= '0;
      row_seen_q <= 1'b0;
    end else if (en_i) begin
      alive_q <= alive_d;
      pos_q <= pos_d;
      fidx_q <= fidx_d;
      phase_q <= phase_d;
      neg_q <= neg_d;
      acc_q <= acc_d;
      row_seen_q <= row_seen_d;
    end
  end

  `PCLP_ASSERT(a_acc_cap, clk_i, rst_ni, acc_q <= RowCap)
  `PCLP_ASSERT(a_fidx_range, clk_i, rst_ni, fidx_q < 3'(Channels))
  `PCLP_ASSERT(a_rows_exclusive, clk_i, rst_ni,
    !(alive_q[2] && alive_q[3] && pos_q >= 6'(LenCell)))
endmodule

// ===== sv/pclp_store.sv =====
module pclp_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pclp_pkg::ctrl_t     ctrl_i,
  output logic [15:0]         trow_o,
  output logic [15:0]         prow_o,
  output logic [7*16-1:0]     values_o
);
  import pclp_pkg::*;
  `include "pressure_command_line_parser_core_macros.svh"

  logic [15:0] pend_q [Channels];
  logic [15:0] val_q [Channels];
  logic [15:0] trow_q, prow_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.write_pending) pend_q[ctrl_i.pend_index] <= ctrl_i.value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Channels; k++) val_q[k] <= '0;
      trow_q <= '0;
      prow_q <= '0;
    end else begin
      if (ctrl_i.commit_sensor) begin
        for (int k = 0; k < Channels - 1; k++) val_q[k] <= pend_q[k];
        val_q[Channels-1] <= ctrl_i.value;
      end
      if (ctrl_i.commit_time) trow_q <= ctrl_i.row;
      if (ctrl_i.commit_pres) prow_q <= ctrl_i.row;
    end
  end

  always_comb begin
    for (int k = 0; k < Channels; k++) values_o[k*16 +: 16] = val_q[k];
  end
  assign trow_o = trow_q;
  assign prow_o = prow_q;

  `PCLP_ASSERT(a_one_commit, clk_i, rst_ni,
    $countones({ctrl_i.commit_sensor, ctrl_i.commit_time, ctrl_i.commit_pres}) <= 1)
  `PCLP_ASSERT_NEXT(a_time_kept, clk_i, rst_ni, !ctrl_i.commit_time,
    trow_q == $past(trow_q))
  `PCLP_ASSERT_NEXT(a_time_load, clk_i, rst_ni, ctrl_i.commit_time,
    trow_q == $past(ctrl_i.row))
endmodule

// ===== sv/pressure_command_line_parser_core.sv =====
// Parses one text line per character transfer (tlast on the final character) and
// gives one result transfer per line with the message kind and the stored rows and
// sensor values in tenths. A character is taken every cycle unless stalled; the result
// appears the cycle after tlast, and a one-entry output register with a skid entry
// lets input continue while a result waits, so only two unread results stall input.
module pressure_command_line_parser_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // character[7:0]
  input  logic          s_axis_tlast,   // line_end
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [151:0]  m_axis_tdata    // kind[2:0], time row, pressure row, pressure_0..6
);
  import pclp_pkg::*;
  `include "pressure_command_line_parser_core_macros.svh"

  item_t       item;
  ctrl_t       ctrl;
  logic        en;
  logic [15:0] trow, prow;
  logic [7*16-1:0] vals;
  logic        res_pend_q;
  kind_e       res_kind_q;
  logic        ov_q;
  logic [151:0] ov_data_q;
  logic [151:0] cur_data;

  assign item.character = s_axis_tdata;
  assign item.line_end = s_axis_tlast;
  assign s_axis_tready = !(ov_q && res_pend_q);
  assign en = s_axis_tvalid && s_axis_tready;

  pclp_scan u_scan (.clk_i, .rst_ni, .en_i(en), .item_i(item), .ctrl_o(ctrl));
  pclp_store u_store (.clk_i, .rst_ni, .ctrl_i(ctrl), .trow_o(trow),
    .prow_o(prow), .values_o(vals));

  assign cur_data = {5'b00000, vals, prow, trow, res_kind_q};
  assign m_axis_tvalid = ov_q || res_pend_q;
  assign m_axis_tdata = ov_q ? ov_data_q : cur_data;

  // The live result reads the stored registers, so it is frozen into the skid entry
  // whenever it is not taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_pend_q <= 1'b0;
      res_kind_q <= KIND_INVALID;
      ov_q <= 1'b0;
    end else begin
      if (ov_q) begin
        if (m_axis_tready) begin
          ov_q <= res_pend_q;
          res_pend_q <= 1'b0;
        end
      end else if (res_pend_q && !m_axis_tready) begin
        ov_q <= 1'b1;
        res_pend_q <= 1'b0;
      end else begin
        res_pend_q <= 1'b0;
      end
      if (ctrl.emit) begin
        res_pend_q <= 1'b1;
        res_kind_q <= ctrl.kind;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ov_q && m_axis_tready) ov_data_q <= cur_data;
    else if (!ov_q && res_pend_q && !m_axis_tready) ov_data_q <= cur_data;
  end

  `PCLP_ASSERT(a_no_input_when_full, clk_i, rst_ni, !(ov_q && res_pend_q && ctrl.emit))
  `PCLP_ASSERT_NEXT(a_emit_shows, clk_i, rst_ni, ctrl.emit, m_axis_tvalid)
  `PCLP_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready && ov_q, ov_q)
endmodule
